[hw/rtl/assert_macros.svh]
// assertion helpers used by the lexer rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define ASSERT_IMPLY(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_IMPLY(lbl, ck, rn, ante, cons)
`define ASSERT_NEXT(lbl, ck, rn, ante, cons)

`endif

`endif

[hw/rtl/kllc_pkg.sv]
`default_nettype none

package kllc_pkg;

  // sizes
  localparam int CP_BITS      = 21;
  localparam int MAX_WORD_LEN = 7;
  localparam int WLEN_BITS    = $clog2(MAX_WORD_LEN + 1);
  localparam int WIDX_BITS    = $clog2(MAX_WORD_LEN);
  localparam int POS_BITS     = 24;
  localparam int DEPTH_BITS   = 16;
  localparam int KW_COUNT     = 16;
  localparam int KW_SLOTS     = 7;
  localparam int KW_BITS      = 4;
  localparam int FIFO_DEPTH   = 4;
  localparam int FPTR_BITS    = $clog2(FIFO_DEPTH);
  localparam int FCNT_BITS    = $clog2(FIFO_DEPTH + 1);

  typedef logic [CP_BITS-1:0]    cp_t;
  typedef logic [POS_BITS-1:0]   pos_t;
  typedef logic [DEPTH_BITS-1:0] depth_t;
  typedef logic [WLEN_BITS-1:0]  wlen_t;
  typedef logic [KW_BITS-1:0]    kw_idx_t;

  // error codes
  typedef enum logic [2:0] {
    ERR_BAD_CHAR   = 3'd0,
    ERR_TOO_LONG   = 3'd1,
    ERR_UNKNOWN    = 3'd2,
    ERR_UNMATCHED  = 3'd3,
    ERR_BREAK_OUT  = 3'd4,
    ERR_UNBALANCED = 3'd5
  } err_code_t;

  // keywords with a loop meaning
  localparam kw_idx_t KW_OPEN  = 4'd7;
  localparam kw_idx_t KW_CLOSE = 4'd8;
  localparam kw_idx_t KW_BREAK = 4'd9;

  // special characters
  localparam cp_t CP_NUL     = 21'h00;
  localparam cp_t CP_TAB     = 21'h09;
  localparam cp_t CP_CR      = 21'h0D;
  localparam cp_t CP_NEWLINE = 21'h0A;
  localparam cp_t CP_SPACE   = 21'h20;
  localparam cp_t CP_HASH    = 21'h23;

  // item payloads
  typedef struct packed {
    logic [CP_BITS-1:0] code_point;
    logic               end_of_text;
  } in_item_t;

  typedef struct packed {
    logic                is_error;
    logic [KW_BITS-1:0]  command_code;
    logic [2:0]          error_code;
    logic [POS_BITS-1:0] line_number;
    logic [POS_BITS-1:0] column_number;
    logic                last_of_run;
  } out_item_t;

  // keyword spelling, all code points below 0x100, unused slots zero
  localparam logic [7:0] KW_TEXT [KW_COUNT][KW_SLOTS] = '{
    '{8'h6D, 8'h61, 8'h72, 8'h69, 8'h63, 8'hF3, 8'h6E},
    '{8'h6D, 8'h61, 8'h72, 8'h61, 8'h63, 8'h6F, 8'h00},
    '{8'h77, 8'h65, 8'hF3, 8'h6E, 8'h00, 8'h00, 8'h00},
    '{8'h61, 8'h77, 8'h65, 8'h6F, 8'h6E, 8'h61, 8'h6F},
    '{8'h6D, 8'h61, 8'h72, 8'h61, 8'h63, 8'h61, 8'h00},
    '{8'h63, 8'h68, 8'h75, 8'h63, 8'h68, 8'h61, 8'h00},
    '{8'h70, 8'h75, 8'h74, 8'h61, 8'h00, 8'h00, 8'h00},
    '{8'h70, 8'h69, 8'h63, 8'h68, 8'h75, 8'h6C, 8'h61},
    '{8'h74, 8'h75, 8'h6C, 8'h61, 8'h00, 8'h00, 8'h00},
    '{8'h70, 8'h69, 8'h63, 8'h6F, 8'h00, 8'h00, 8'h00},
    '{8'h63, 8'h74, 8'h6D, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h71, 8'h75, 8'hE9, 8'h77, 8'h65, 8'hE1, 8'h00},
    '{8'h63, 8'h68, 8'hFA, 8'h70, 8'h61, 8'h6C, 8'h61},
    '{8'h62, 8'h72, 8'hED, 8'h67, 8'h69, 8'h64, 8'h6F},
    '{8'h70, 8'h65, 8'h72, 8'h6B, 8'h69, 8'h6E, 8'h00},
    '{8'h6D, 8'h69, 8'h65, 8'h72, 8'h64, 8'h61, 8'h00}
  };

  localparam int KW_LEN [KW_COUNT] = '{7, 6, 4, 7, 6, 6, 4, 7, 4, 4, 3, 6, 7, 7, 6, 6};

  // accepted word letters
  localparam int NUM_LETTERS = 24;
  localparam logic [7:0] LETTERS [NUM_LETTERS] = '{
    8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h67, 8'h68, 8'h69, 8'h6B, 8'h6C,
    8'h6D, 8'h6E, 8'h6F, 8'h70, 8'h71, 8'h72, 8'h74, 8'h75, 8'h77,
    8'hE1, 8'hE9, 8'hED, 8'hF3, 8'hFA
  };

endpackage

`default_nettype wire

[hw/rtl/keyword_lexer_with_loop_check.sv]
`default_nettype none
// channel | ports                          | payload
// --------+--------------------------------+------------------------
// input   | in_valid, in_ready, in_data    | code point, end flag
// output  | out_valid, out_ready, out_data | command or error report
//
// one item per cycle: an input register feeds the keyword compare and state
// update, which writes zero, one or two results into a four-entry output fifo.
// an item leaves the input register when the fifo holds at most two results,
// so the rate drops only while the consumer stalls.
// reset is synchronous and active low; after an error the block still takes
// items but reports nothing until reset.

`include "assert_macros.svh"

module keyword_lexer_with_loop_check (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      in_valid,
  output logic                     in_ready,
  input  wire kllc_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire                      out_ready,
  output kllc_pkg::out_item_t      out_data
);
  import kllc_pkg::*;

  // input register
  logic     st_valid_r;
  in_item_t st_data_r;
  logic     st_adv;

  // lexer state
  cp_t    word_r [MAX_WORD_LEN];
  cp_t    word_nxt [MAX_WORD_LEN];
  wlen_t  wlen_r, wlen_nxt;
  logic   in_comment_r, in_comment_nxt;
  pos_t   line_r, line_nxt;
  pos_t   col_r, col_nxt;
  depth_t depth_r, depth_nxt;
  logic   halted_r, halted_nxt;

  // results of the current item
  out_item_t res0, res1;
  logic [1:0] push_raw, push_cnt;

  // output fifo
  out_item_t fifo_r [FIFO_DEPTH];
  logic [FPTR_BITS-1:0] wr_ptr_r, rd_ptr_r;
  logic [FCNT_BITS-1:0] fifo_cnt_r;
  logic pop;

  // character classes and keyword match
  cp_t     cp;
  logic    is_bnd, is_letter, kw_hit;
  kw_idx_t kw_idx;
  pos_t    start_col;

  function automatic out_item_t mk_res(logic err, kw_idx_t cmd, err_code_t ec,
                                       pos_t line, pos_t col);
    out_item_t r;
    r.is_error      = err;
    r.command_code  = cmd;
    r.error_code    = ec;
    r.line_number   = line;
    r.column_number = col;
    r.last_of_run   = 1'b0;
    return r;
  endfunction

  // advance the input register when two fifo slots are sure to be free
  assign st_adv   = st_valid_r && (fifo_cnt_r <= FCNT_BITS'(FIFO_DEPTH - 2));
  assign in_ready = !st_valid_r || st_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_valid_r <= 1'b0;
    end else if (in_ready) begin
      st_valid_r <= in_valid;
    end
    if (in_ready && in_valid) begin
      st_data_r <= in_data;
    end
  end

  // classify the character
  assign cp     = st_data_r.end_of_text ? CP_NUL : st_data_r.code_point;
  assign is_bnd = (cp == CP_SPACE) || ((cp >= CP_TAB) && (cp <= CP_CR)) ||
                  (cp == CP_HASH) || (cp == CP_NUL);

  always_comb begin
    is_letter = 1'b0;
    for (int i = 0; i < NUM_LETTERS; i++) begin
      if (cp == {{(CP_BITS-8){1'b0}}, LETTERS[i]}) is_letter = 1'b1;
    end
  end

  // parallel compare against every keyword
  always_comb begin
    logic eq;
    kw_hit = 1'b0;
    kw_idx = '0;
    for (int k = 0; k < KW_COUNT; k++) begin
      eq = (wlen_r == WLEN_BITS'(KW_LEN[k]));
      for (int i = 0; i < KW_SLOTS; i++) begin
        if (word_r[i] != {{(CP_BITS-8){1'b0}}, KW_TEXT[k][i]}) eq = 1'b0;
      end
      if (eq && !kw_hit) begin
        kw_hit = 1'b1;
        kw_idx = KW_BITS'(k);
      end
    end
  end

  // start column of the pending word, clamped at zero
  assign start_col = (col_r >= POS_BITS'(wlen_r)) ? (col_r - POS_BITS'(wlen_r)) : '0;

  // state update and results for one item
  always_comb begin
    logic stop;
    logic err;
    err_code_t ec;
    word_nxt       = word_r;
    wlen_nxt       = wlen_r;
    in_comment_nxt = in_comment_r;
    line_nxt       = line_r;
    col_nxt        = col_r;
    depth_nxt      = depth_r;
    halted_nxt     = halted_r;
    res0           = '0;
    res1           = '0;
    push_raw       = 2'd0;
    stop           = 1'b0;
    err            = 1'b0;
    ec             = ERR_UNKNOWN;
    if (!halted_r) begin
      if (cp == CP_HASH) in_comment_nxt = 1'b1;

      if (is_bnd) begin
        // flush a pending word
        if (wlen_r != '0) begin
          for (int i = 0; i < MAX_WORD_LEN; i++) word_nxt[i] = '0;
          wlen_nxt = '0;
          if (!kw_hit) begin
            err = 1'b1;
            ec  = ERR_UNKNOWN;
          end else if (kw_idx == KW_OPEN) begin
            if (depth_r != '1) depth_nxt = depth_r + 1'b1;
          end else if (kw_idx == KW_CLOSE) begin
            if (depth_r == '0) begin
              err = 1'b1;
              ec  = ERR_UNMATCHED;
            end else begin
              depth_nxt = depth_r - 1'b1;
            end
          end else if (kw_idx == KW_BREAK) begin
            if (depth_r == '0) begin
              err = 1'b1;
              ec  = ERR_BREAK_OUT;
            end
          end
          if (err) begin
            res0       = mk_res(1'b1, '0, ec, line_r, start_col);
            halted_nxt = 1'b1;
            stop       = 1'b1;
          end else begin
            res0 = mk_res(1'b0, kw_idx, ERR_BAD_CHAR, line_r, start_col);
          end
          push_raw = 2'd1;
        end
      end else if (!in_comment_r) begin
        // gather a letter
        if (!is_letter) begin
          res0       = mk_res(1'b1, '0, ERR_BAD_CHAR, line_r, col_r);
          push_raw   = 2'd1;
          halted_nxt = 1'b1;
          stop       = 1'b1;
        end else if (wlen_r >= WLEN_BITS'(MAX_WORD_LEN)) begin
          res0       = mk_res(1'b1, '0, ERR_TOO_LONG, line_r, start_col);
          push_raw   = 2'd1;
          halted_nxt = 1'b1;
          stop       = 1'b1;
        end else begin
          word_nxt[wlen_r[WIDX_BITS-1:0]] = cp;
          wlen_nxt = wlen_r + 1'b1;
        end
      end

      if (!stop) begin
        // position tracking
        if (cp == CP_NEWLINE) begin
          if (line_r != '1) line_nxt = line_r + 1'b1;
          col_nxt        = POS_BITS'(1);
          in_comment_nxt = 1'b0;
        end else if (col_r != '1) begin
          col_nxt = col_r + 1'b1;
        end
        // balance check at end of text
        if (st_data_r.end_of_text && (depth_nxt != '0)) begin
          if (push_raw == 2'd0) begin
            res0     = mk_res(1'b1, '0, ERR_UNBALANCED, line_r, col_r);
            push_raw = 2'd1;
          end else begin
            res1     = mk_res(1'b1, '0, ERR_UNBALANCED, line_r, col_r);
            push_raw = 2'd2;
          end
          halted_nxt = 1'b1;
        end
      end

      // mark the final result of the item
      if (push_raw == 2'd1) res0.last_of_run = 1'b1;
      if (push_raw == 2'd2) res1.last_of_run = 1'b1;
    end
  end

  assign push_cnt = st_adv ? push_raw : 2'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_WORD_LEN; i++) word_r[i] <= '0;
      wlen_r       <= '0;
      in_comment_r <= 1'b0;
      line_r       <= POS_BITS'(1);
      col_r        <= POS_BITS'(1);
      depth_r      <= '0;
      halted_r     <= 1'b0;
    end else if (st_adv) begin
      word_r       <= word_nxt;
      wlen_r       <= wlen_nxt;
      in_comment_r <= in_comment_nxt;
      line_r       <= line_nxt;
      col_r        <= col_nxt;
      depth_r      <= depth_nxt;
      halted_r     <= halted_nxt;
    end
  end

  // output fifo
  assign pop       = out_valid && out_ready;
  assign out_valid = (fifo_cnt_r != '0);
  assign out_data  = fifo_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) fifo_r[wr_ptr_r] <= res0;
    if (push_cnt == 2'd2) fifo_r[wr_ptr_r + FPTR_BITS'(1)] <= res1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      fifo_cnt_r <= '0;
    end else begin
      wr_ptr_r   <= wr_ptr_r + FPTR_BITS'(push_cnt);
      rd_ptr_r   <= rd_ptr_r + FPTR_BITS'(pop);
      fifo_cnt_r <= fifo_cnt_r + FCNT_BITS'(push_cnt) - FCNT_BITS'(pop);
    end
  end

  // checks
  `ASSERT_IMPLY(a_fifo_bound, clk, rst_n, 1'b1, fifo_cnt_r <= FCNT_BITS'(FIFO_DEPTH))
  `ASSERT_IMPLY(a_halt_silent, clk, rst_n, halted_r, push_cnt == 2'd0)
  `ASSERT_NEXT(a_halt_sticky, clk, rst_n, halted_r, halted_r)
  `ASSERT_IMPLY(a_two_at_end, clk, rst_n, push_cnt == 2'd2, st_data_r.end_of_text)
  `ASSERT_IMPLY(a_word_bound, clk, rst_n, 1'b1, wlen_r <= WLEN_BITS'(MAX_WORD_LEN))

endmodule

`default_nettype wire

[verif/kllc_checker.sv]
`default_nettype none

module kllc_checker (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      in_valid,
  input  wire                      in_ready,
  input  wire kllc_pkg::in_item_t  in_data,
  input  wire                      out_valid,
  input  wire                      out_ready,
  input  wire kllc_pkg::out_item_t out_data,
  output int                       fail_count,
  output int                       pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import kllc_pkg::*;

  // keyword spelling in table order, unused slots zero
  localparam cp_t SPELLING [KW_COUNT][KW_SLOTS] = '{
    '{'h6D, 'h61, 'h72, 'h69, 'h63, 'hF3, 'h6E},
    '{'h6D, 'h61, 'h72, 'h61, 'h63, 'h6F, 'h00},
    '{'h77, 'h65, 'hF3, 'h6E, 'h00, 'h00, 'h00},
    '{'h61, 'h77, 'h65, 'h6F, 'h6E, 'h61, 'h6F},
    '{'h6D, 'h61, 'h72, 'h61, 'h63, 'h61, 'h00},
    '{'h63, 'h68, 'h75, 'h63, 'h68, 'h61, 'h00},
    '{'h70, 'h75, 'h74, 'h61, 'h00, 'h00, 'h00},
    '{'h70, 'h69, 'h63, 'h68, 'h75, 'h6C, 'h61},
    '{'h74, 'h75, 'h6C, 'h61, 'h00, 'h00, 'h00},
    '{'h70, 'h69, 'h63, 'h6F, 'h00, 'h00, 'h00},
    '{'h63, 'h74, 'h6D, 'h00, 'h00, 'h00, 'h00},
    '{'h71, 'h75, 'hE9, 'h77, 'h65, 'hE1, 'h00},
    '{'h63, 'h68, 'hFA, 'h70, 'h61, 'h6C, 'h61},
    '{'h62, 'h72, 'hED, 'h67, 'h69, 'h64, 'h6F},
    '{'h70, 'h65, 'h72, 'h6B, 'h69, 'h6E, 'h00},
    '{'h6D, 'h69, 'h65, 'h72, 'h64, 'h61, 'h00}
  };

  // lexer state as the block should hold it
  cp_t       word [MAX_WORD_LEN];
  int        word_len;
  bit        in_comment;
  pos_t      cur_line;
  pos_t      cur_col;
  depth_t    loop_depth;
  bit        halted;

  out_item_t expected_reports [$];
  out_item_t want;
  int        mismatches = 0;

  function automatic bit is_boundary(cp_t c);
    return c == CP_SPACE || (c >= CP_TAB && c <= CP_CR) || c == CP_HASH || c == CP_NUL;
  endfunction

  function automatic bit is_letter(cp_t c);
    case (c)
      'h61, 'h62, 'h63, 'h64, 'h65, 'h67, 'h68, 'h69, 'h6B, 'h6C, 'h6D, 'h6E,
      'h6F, 'h70, 'h71, 'h72, 'h74, 'h75, 'h77, 'hE1, 'hE9, 'hED, 'hF3, 'hFA: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  // index of the keyword spelled by the pending word, -1 if none
  function automatic int find_keyword();
    int len;
    int k;
    int i;
    bit same;
    for (k = 0; k < KW_COUNT; k++) begin
      len = 0;
      while (len < KW_SLOTS && SPELLING[k][len] != '0) len++;
      same = (len == word_len);
      for (i = 0; i < word_len; i++) begin
        if (word[i] != SPELLING[k][i]) same = 1'b0;
      end
      if (same) return k;
    end
    return -1;
  endfunction

  function automatic out_item_t cmd_report(kw_idx_t k, pos_t line, pos_t col);
    out_item_t r;
    r = '0;
    r.command_code  = k;
    r.line_number   = line;
    r.column_number = col;
    return r;
  endfunction

  function automatic out_item_t err_report(err_code_t code, pos_t line, pos_t col);
    out_item_t r;
    r = '0;
    r.is_error      = 1'b1;
    r.error_code    = code;
    r.line_number   = line;
    r.column_number = col;
    return r;
  endfunction

  function automatic string describe(out_item_t r);
    return $sformatf("err=%0d cmd=%0d code=%0d line=%0d col=%0d last=%0d", r.is_error,
                     r.command_code, r.error_code, r.line_number, r.column_number,
                     r.last_of_run);
  endfunction

  // advance the lexer by one character and queue the reports it causes
  task automatic lex_char(input cp_t raw, input logic eot);
    cp_t       c;
    pos_t      line_here;
    pos_t      col_here;
    pos_t      start;
    int        k;
    int        n;
    bit        failed;
    err_code_t code;
    out_item_t found [2];
    if (halted) return;
    c = eot ? CP_NUL : raw;
    line_here = cur_line;
    col_here = cur_col;
    start = (col_here >= pos_t'(word_len)) ? col_here - pos_t'(word_len) : '0;
    n = 0;
    failed = 1'b0;
    code = ERR_BAD_CHAR;
    if (c == CP_HASH) in_comment = 1'b1;

    // word boundary: flush and match the pending word
    if (is_boundary(c)) begin
      if (word_len > 0) begin
        k = find_keyword();
        if (k < 0) begin
          failed = 1'b1;
          code = ERR_UNKNOWN;
        end else if (kw_idx_t'(k) == KW_OPEN) begin
          if (loop_depth != '1) loop_depth = loop_depth + 1'b1;
        end else if (kw_idx_t'(k) == KW_CLOSE) begin
          if (loop_depth == '0) begin
            failed = 1'b1;
            code = ERR_UNMATCHED;
          end else begin
            loop_depth = loop_depth - 1'b1;
          end
        end else if (kw_idx_t'(k) == KW_BREAK && loop_depth == '0) begin
          failed = 1'b1;
          code = ERR_BREAK_OUT;
        end
        foreach (word[i]) word[i] = '0;
        word_len = 0;
        if (!failed) begin
          found[n] = cmd_report(kw_idx_t'(k), line_here, start);
          n++;
        end
      end
    // letter outside a comment: grow the word
    end else if (!in_comment) begin
      if (!is_letter(c)) begin
        failed = 1'b1;
        code = ERR_BAD_CHAR;
        start = col_here;
      end else if (word_len >= MAX_WORD_LEN) begin
        failed = 1'b1;
        code = ERR_TOO_LONG;
      end else begin
        word[word_len] = c;
        word_len++;
      end
    end

    if (failed) begin
      halted = 1'b1;
      found[0] = err_report(code, line_here, start);
      n = 1;
    end else begin
      // position tracking, both saturating
      if (c == CP_NEWLINE) begin
        if (cur_line != '1) cur_line = cur_line + 1'b1;
        cur_col = pos_t'(1);
        in_comment = 1'b0;
      end else if (cur_col != '1) begin
        cur_col = cur_col + 1'b1;
      end
      // balance check at end of text
      if (eot && loop_depth != '0) begin
        found[n] = err_report(ERR_UNBALANCED, line_here, col_here);
        n++;
        halted = 1'b1;
      end
    end

    if (n > 0) found[n-1].last_of_run = 1'b1;
    for (k = 0; k < n; k++) expected_reports.push_back(found[k]);
  endtask

  // watch both channels, predict on accepted inputs, compare accepted reports
  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (word[i]) word[i] = '0;
      word_len = 0;
      in_comment = 1'b0;
      cur_line = pos_t'(1);
      cur_col = pos_t'(1);
      loop_depth = '0;
      halted = 1'b0;
      expected_reports.delete();
    end else begin
      if (in_valid && in_ready) lex_char(in_data.code_point, in_data.end_of_text);
      if (out_valid && out_ready) begin
        if (expected_reports.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected report: %s", describe(out_data));
        end else begin
          want = expected_reports.pop_front();
          if (out_data !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("report mismatch: expected %s", describe(want));
              $display("                 actual   %s", describe(out_data));
            end
          end
        end
      end
    end
    fail_count <= mismatches;
    pending <= expected_reports.size();
  end

endmodule

`default_nettype wire

[verif/keyword_lexer_with_loop_check_tb.sv]
`default_nettype none

module keyword_lexer_with_loop_check_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import kllc_pkg::*;

  localparam int RANDOM_ITEMS = 2000;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int MAX_CP       = 'h10FFFF;
  localparam int MAX_NESTING  = 12;

  // keyword spelling used to build source text
  localparam cp_t SPELLING [KW_COUNT][KW_SLOTS] = '{
    '{'h6D, 'h61, 'h72, 'h69, 'h63, 'hF3, 'h6E},
    '{'h6D, 'h61, 'h72, 'h61, 'h63, 'h6F, 'h00},
    '{'h77, 'h65, 'hF3, 'h6E, 'h00, 'h00, 'h00},
    '{'h61, 'h77, 'h65, 'h6F, 'h6E, 'h61, 'h6F},
    '{'h6D, 'h61, 'h72, 'h61, 'h63, 'h61, 'h00},
    '{'h63, 'h68, 'h75, 'h63, 'h68, 'h61, 'h00},
    '{'h70, 'h75, 'h74, 'h61, 'h00, 'h00, 'h00},
    '{'h70, 'h69, 'h63, 'h68, 'h75, 'h6C, 'h61},
    '{'h74, 'h75, 'h6C, 'h61, 'h00, 'h00, 'h00},
    '{'h70, 'h69, 'h63, 'h6F, 'h00, 'h00, 'h00},
    '{'h63, 'h74, 'h6D, 'h00, 'h00, 'h00, 'h00},
    '{'h71, 'h75, 'hE9, 'h77, 'h65, 'hE1, 'h00},
    '{'h63, 'h68, 'hFA, 'h70, 'h61, 'h6C, 'h61},
    '{'h62, 'h72, 'hED, 'h67, 'h69, 'h64, 'h6F},
    '{'h70, 'h65, 'h72, 'h6B, 'h69, 'h6E, 'h00},
    '{'h6D, 'h69, 'h65, 'h72, 'h64, 'h61, 'h00}
  };

  localparam cp_t WORD_LETTERS [24] = '{
    'h61, 'h62, 'h63, 'h64, 'h65, 'h67, 'h68, 'h69, 'h6B, 'h6C, 'h6D, 'h6E,
    'h6F, 'h70, 'h71, 'h72, 'h74, 'h75, 'h77, 'hE1, 'hE9, 'hED, 'hF3, 'hFA
  };

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  int        fail_count;
  int        pending;

  int        cycle_count = 0;
  int        items_sent = 0;
  int        burst_left = 0;
  int        gap;
  int        nesting = 0;
  int        rx_mode = 0;
  int        rx_left = 0;
  bit        drained = 1'b0;

  keyword_lexer_with_loop_check dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  kllc_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #10 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // receiver: phases of full rate, random stalls and solid stalls
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = (rx_mode == 2) ? $urandom_range(1, 10) : $urandom_range(5, 50);
    end
    rx_left--;
    case (rx_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      2: out_ready <= 1'b0;
      default: out_ready <= ($urandom_range(0, 4) != 0);
    endcase
  end

  function automatic bit is_word_letter(cp_t c);
    foreach (WORD_LETTERS[i]) if (WORD_LETTERS[i] == c) return 1'b1;
    return 1'b0;
  endfunction

  function automatic cp_t any_letter();
    return WORD_LETTERS[$urandom_range(0, 23)];
  endfunction

  // one item, with bursts and gaps on the sending side
  task automatic send(input cp_t c, input logic eot);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 16);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= '{code_point: c, end_of_text: eot};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  // hold the sender until every predicted report has been seen
  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic send_word(input kw_idx_t k);
    for (int i = 0; i < KW_SLOTS; i++) begin
      if (SPELLING[k][i] != '0) send(SPELLING[k][i], 1'b0);
    end
  endtask

  task automatic send_letters(input int n);
    repeat (n) send(any_letter(), 1'b0);
  endtask

  // comment body of random code points, closed by a newline
  task automatic send_comment_tail();
    cp_t c;
    repeat ($urandom_range(0, 6)) begin
      c = cp_t'($urandom_range(0, MAX_CP));
      if (c == CP_NEWLINE) c = CP_HASH;
      send(c, 1'b0);
    end
    send(CP_NEWLINE, 1'b0);
  endtask

  // some boundary after a word
  task automatic send_separator();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: send(CP_SPACE, 1'b0);
      4: send(cp_t'($urandom_range(CP_TAB, CP_CR)), 1'b0);
      5: send(CP_NEWLINE, 1'b0);
      6: send(CP_NUL, 1'b0);
      7: begin
        send(CP_HASH, 1'b0);
        send_comment_tail();
      end
      8: send(nesting == 0 ? cp_t'($urandom_range(0, MAX_CP)) : CP_SPACE, nesting == 0);
      default: send(CP_SPACE, 1'b0);
    endcase
  endtask

  // keyword that keeps the nesting legal
  task automatic send_keyword();
    kw_idx_t k;
    k = kw_idx_t'($urandom_range(0, KW_COUNT - 1));
    if ((k == KW_CLOSE || k == KW_BREAK) && nesting == 0) k = KW_OPEN;
    else if (k == KW_OPEN && nesting >= MAX_NESTING) k = KW_CLOSE;
    if (k == KW_OPEN) nesting++;
    else if (k == KW_CLOSE) nesting--;
    send_word(k);
    send_separator();
  endtask

  // the single error this run ends with, since only reset clears the halt
  task automatic send_fatal();
    cp_t c;
    case ($urandom_range(0, 5))
      0: begin
        send_letters($urandom_range(0, 3));
        do begin
          c = ($urandom_range(0, 1) == 0) ? cp_t'($urandom_range('h21, 'h7F))
                                          : cp_t'($urandom_range(CP_HASH + 1, MAX_CP));
        end while (is_word_letter(c) || c == CP_HASH);
        send(c, 1'b0);
      end
      1: send_letters(MAX_WORD_LEN + 1);
      2: begin
        send_letters($urandom_range(1, 2));
        send(CP_SPACE, 1'b0);
      end
      3: begin
        repeat (nesting + 1) begin
          send_word(KW_CLOSE);
          send(CP_SPACE, 1'b0);
        end
      end
      4: begin
        repeat (nesting) begin
          send_word(KW_CLOSE);
          send(CP_SPACE, 1'b0);
        end
        send_word(KW_BREAK);
        send(CP_SPACE, 1'b0);
      end
      default: begin
        // pending word flushed, then the balance error: two reports
        send_word(KW_OPEN);
        send(CP_SPACE, 1'b0);
        send_word(KW_OPEN);
        send(cp_t'($urandom_range(0, MAX_CP)), 1'b1);
      end
    endcase
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed: loop with break, comment right after a word,
    // highest code point in a comment, end flag flushing a word, other blanks
    send_word(KW_OPEN);
    send(CP_TAB, 1'b0);
    send_word(KW_BREAK);
    send(CP_HASH, 1'b0);
    send(cp_t'(MAX_CP), 1'b0);
    send(CP_NEWLINE, 1'b0);
    send_word(KW_CLOSE);
    send(cp_t'(MAX_CP), 1'b1);
    send(CP_CR, 1'b0);
    send(CP_SPACE, 1'b0);
    send(CP_NUL, 1'b0);

    // random well-formed source text
    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5, 6: send_keyword();
        7: begin
          send(CP_HASH, 1'b0);
          send_comment_tail();
        end
        8: repeat ($urandom_range(1, 3)) send(cp_t'($urandom_range(CP_TAB, CP_CR)), 1'b0);
        default: send_separator();
      endcase
      // one full drain halfway through
      if (!drained && items_sent >= RANDOM_ITEMS / 2) begin
        drain();
        drained = 1'b1;
      end
    end

    // one error, then items the halted block must ignore
    send_fatal();
    repeat (3) begin
      send_word(KW_OPEN);
      send(CP_SPACE, 1'b0);
    end
    send(CP_NUL, 1'b1);

    drain();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
